// File: src/pinhole_camera_ray_generator_assert.svh
// assertion helpers for the ray generator, clocked on clk and disabled in reset
`ifndef PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH
`define PINHOLE_CAMERA_RAY_GENERATOR_ASSERT_SVH
`ifndef SYNTHESIS
// plain property, checked at every edge out of reset
`define PCRG_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same cycle implication
`define PCRG_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);
// next cycle implication
`define PCRG_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCRG_ASSERT(lbl, prop, msg)
`define PCRG_ASSERT_IMPLY(lbl, ante, cons, msg)
`define PCRG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: src/pcrg_pkg.sv
`default_nettype none
package pcrg_pkg;
	localparam int COORD_BITS = 12;
	localparam int FRAC_BITS = 8;
	localparam int UNIT_BITS = 14;
	localparam int COMP_W = 16;
	localparam int VEC_W = 3 * COMP_W;
	localparam int DIM_W = 13;
	localparam int ADDR_W = 6;
	localparam int DATA_W = 64;

	// register indexes, one per 8 byte slot
	localparam logic [2:0] REG_ORIGIN = 3'd0;
	localparam logic [2:0] REG_VIEW = 3'd1;
	localparam logic [2:0] REG_UP = 3'd2;
	localparam logic [2:0] REG_DIST = 3'd3;
	localparam logic [2:0] REG_WIDTH = 3'd4;
	localparam logic [2:0] REG_HEIGHT = 3'd5;

	// basis sequencer states
	typedef enum logic [3:0] {
		B_CROSS_R,
		B_CROSS_T,
		B_LOAD,
		B_NORM,
		B_SQ,
		B_SQRT,
		B_DIV,
		B_SC1,
		B_SC2,
		B_IDLE
	} bstate_t;
endpackage
`default_nettype wire

// File: src/pcrg_pix_if.sv
`default_nettype none
interface pcrg_pix_if;
	logic valid;
	logic ready;
	logic [pcrg_pkg::COORD_BITS-1:0] pixel_x;
	logic [pcrg_pkg::COORD_BITS-1:0] pixel_y;
	modport source (output valid, output pixel_x, output pixel_y, input ready);
	modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface
`default_nettype wire

// File: src/pcrg_ray_if.sv
`default_nettype none
interface pcrg_ray_if;
	logic valid;
	logic ready;
	logic signed [pcrg_pkg::COMP_W-1:0] origin_x;
	logic signed [pcrg_pkg::COMP_W-1:0] origin_y;
	logic signed [pcrg_pkg::COMP_W-1:0] origin_z;
	logic signed [pcrg_pkg::COMP_W-1:0] dir_x;
	logic signed [pcrg_pkg::COMP_W-1:0] dir_y;
	logic signed [pcrg_pkg::COMP_W-1:0] dir_z;
	logic basis_fault;
	logic saturated;
	modport source (output valid, output origin_x, output origin_y, output origin_z,
		output dir_x, output dir_y, output dir_z, output basis_fault, output saturated,
		input ready);
	modport sink (input valid, input origin_x, input origin_y, input origin_z,
		input dir_x, input dir_y, input dir_z, input basis_fault, input saturated,
		output ready);
endinterface
`default_nettype wire

// File: src/pinhole_camera_ray_generator.sv
// pinhole camera primary ray generator
// pix: request of one pixel (pixel_x, pixel_y), valid/ready, taken when both are high
// ray: one request out per pixel, in order: camera origin, Q8.8 direction,
//   basis_fault (zero length view or cross product) and saturated (clipped direction)
// apb port: six registers at byte addresses 0,8,..,40, 64 bit data, pready tied high
// throughput: one pixel per cycle unless the pipeline is full while ray.ready is low,
//   or a basis pass runs; the 17 stage restoring divider divides by (height-1)<<14
// the camera basis (unit view, right and top vectors and the plane term) depends
//   on the registers only; a small sequencer with one shared multiplier, a
//   one bit per cycle square root and a one bit per cycle divider builds it
//   after reset and after every register write, taking longer or shorter as the
//   normalizing shifts vary; pix.ready stays low during that time
// reset: registers take their defaults and the pipeline empties, then the
//   basis pass runs before the first pixel is taken
// stall: a stage moves whenever any stage at or after it is empty, so bubbles
//   close up and new pixels keep entering while a finished ray waits on ray.ready
`default_nettype none
module pinhole_camera_ray_generator (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [pcrg_pkg::ADDR_W-1:0] paddr,
	input  logic [pcrg_pkg::DATA_W-1:0] pwdata,
	output logic [pcrg_pkg::DATA_W-1:0] prdata,
	output logic pready,
	pcrg_pix_if.sink pix,
	pcrg_ray_if.source ray
);
	localparam int NST = 23;     // pipeline stages
	localparam int QB = 17;      // quotient bits per lane
	localparam int DIVS = 5;     // index of first divider stage
	localparam int NUM_W = 46;

	// ---------------- configuration registers ----------------
	logic [pcrg_pkg::VEC_W-1:0] origin_q, view_q, up_q;
	logic [15:0] dist_q;
	logic [pcrg_pkg::DIM_W-1:0] width_q, height_q;
	logic cfg_wr;
	logic [2:0] cfg_idx;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign cfg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q <= '0;
			view_q <= 48'd256;
			up_q <= 48'd16777216;
			dist_q <= 16'd256;
			width_q <= 13'd640;
			height_q <= 13'd480;
		end else if (cfg_wr) begin
			unique case (cfg_idx)
				pcrg_pkg::REG_ORIGIN: origin_q <= pwdata[47:0];
				pcrg_pkg::REG_VIEW: view_q <= pwdata[47:0];
				pcrg_pkg::REG_UP: up_q <= pwdata[47:0];
				pcrg_pkg::REG_DIST: dist_q <= pwdata[15:0];
				pcrg_pkg::REG_WIDTH: width_q <= pwdata[12:0];
				pcrg_pkg::REG_HEIGHT: height_q <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (cfg_idx)
			pcrg_pkg::REG_ORIGIN: prdata = {16'b0, origin_q};
			pcrg_pkg::REG_VIEW: prdata = {16'b0, view_q};
			pcrg_pkg::REG_UP: prdata = {16'b0, up_q};
			pcrg_pkg::REG_DIST: prdata = {48'b0, dist_q};
			pcrg_pkg::REG_WIDTH: prdata = {51'b0, width_q};
			pcrg_pkg::REG_HEIGHT: prdata = {51'b0, height_q};
			default: prdata = '0;
		endcase
	end

	// clamped dimensions minus one
	logic [11:0] w1, h1;
	logic [25:0] den;
	always_comb begin
		if (width_q < 13'd2) w1 = 12'd1;
		else if (width_q > 13'd4096) w1 = 12'd4095;
		else w1 = 12'(width_q - 13'd1);
		if (height_q < 13'd2) h1 = 12'd1;
		else if (height_q > 13'd4096) h1 = 12'd4095;
		else h1 = 12'(height_q - 13'd1);
	end
	assign den = {h1, 14'b0};

	logic signed [15:0] d_v [3];
	logic signed [15:0] up_v [3];
	logic signed [15:0] org_v [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			d_v[i] = view_q[16*i +: 16];
			up_v[i] = up_q[16*i +: 16];
			org_v[i] = origin_q[16*i +: 16];
		end
	end

	// ---------------- basis sequencer ----------------
	pcrg_pkg::bstate_t bstate_q, bstate_d;
	logic busy;
	logic [2:0] cnt_q;
	logic [1:0] vsel_q, comp_q;
	logic [3:0] dbit_q;
	logic fault_q;
	logic signed [49:0] mul_q, acc_q;
	logic signed [32:0] rv_q [3];
	logic signed [48:0] tv_q [3];
	logic [48:0] mag_q [3];
	logic neg_q [3];
	logic [50:0] sum_q, n_q, bit_q;
	logic [51:0] root_q;
	logic [39:0] rem_q;
	logic [14:0] quo_q;
	logic signed [15:0] du_q [3], ru_q [3], tu_q [3];
	logic signed [31:0] tmp_q [3];
	logic signed [44:0] a_q [3];

	function automatic logic [1:0] nxt1(input logic [1:0] c);
		unique case (c)
			2'd0: nxt1 = 2'd1;
			2'd1: nxt1 = 2'd2;
			default: nxt1 = 2'd0;
		endcase
	endfunction

	function automatic logic [1:0] nxt2(input logic [1:0] c);
		unique case (c)
			2'd0: nxt2 = 2'd2;
			2'd1: nxt2 = 2'd0;
			default: nxt2 = 2'd1;
		endcase
	endfunction

	function automatic logic [1:0] idx3(input logic [1:0] c);
		idx3 = (c == 2'd3) ? 2'd0 : c;
	endfunction

	// shared multiplier operands
	logic signed [31:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [65:0] prod;
	logic [1:0] xa, xb, sidx;
	always_comb begin
		xa = cnt_q[0] ? nxt2(cnt_q[2:1]) : nxt1(cnt_q[2:1]);
		xb = cnt_q[0] ? nxt1(cnt_q[2:1]) : nxt2(cnt_q[2:1]);
		sidx = idx3(cnt_q[1:0]);
		mul_a = '0;
		mul_b = '0;
		unique case (bstate_q)
			pcrg_pkg::B_CROSS_R: begin
				mul_a = 32'(d_v[xa]);
				mul_b = 34'(up_v[xb]);
			end
			pcrg_pkg::B_CROSS_T: begin
				mul_a = 32'(d_v[xa]);
				mul_b = 34'(rv_q[xb]);
			end
			pcrg_pkg::B_SQ: begin
				mul_a = $signed({8'b0, mag_q[sidx][23:0]});
				mul_b = $signed({10'b0, mag_q[sidx][23:0]});
			end
			pcrg_pkg::B_SC1: begin
				mul_a = 32'(du_q[sidx]);
				mul_b = $signed({18'b0, dist_q});
			end
			pcrg_pkg::B_SC2: begin
				mul_a = tmp_q[sidx];
				mul_b = $signed({22'b0, h1});
			end
			default: ;
		endcase
	end
	assign prod = mul_a * mul_b;

	// vector being unitized
	logic signed [49:0] lv [3];
	logic [48:0] lmag [3];
	logic [48:0] m01, mmax;
	logic norm_zero, norm_big, norm_small;
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			unique case (vsel_q)
				2'd0: lv[i] = 50'(d_v[i]);
				2'd1: lv[i] = 50'(rv_q[i]);
				default: lv[i] = 50'(tv_q[i]);
			endcase
			lmag[i] = lv[i][49] ? 49'(-lv[i]) : 49'(lv[i]);
		end
		m01 = (mag_q[0] > mag_q[1]) ? mag_q[0] : mag_q[1];
		mmax = (m01 > mag_q[2]) ? m01 : mag_q[2];
		norm_zero = (mmax == '0);
		norm_big = (mmax[48:24] != '0);
		norm_small = (mmax[48:23] == '0);
	end

	// square root and division steps
	logic [51:0] sq_t;
	logic sq_ge;
	logic [39:0] dv;
	logic dv_ge;
	logic [14:0] qn;
	logic signed [15:0] unit_val;
	logic [1:0] comp_nx;
	logic [2:0] pc;
	always_comb begin
		sq_t = root_q + {1'b0, bit_q};
		sq_ge = ({1'b0, n_q} >= sq_t);
		dv = 40'(root_q[24:0]) << dbit_q;
		dv_ge = (rem_q >= dv);
		qn = quo_q | (dv_ge ? (15'd1 << dbit_q) : 15'd0);
		unit_val = neg_q[comp_q] ? -$signed({1'b0, qn}) : $signed({1'b0, qn});
		comp_nx = comp_q + 2'd1;
		pc = cnt_q - 3'd1;
	end

	always_comb begin
		bstate_d = bstate_q;
		unique case (bstate_q)
			pcrg_pkg::B_CROSS_R: if (cnt_q == 3'd6) bstate_d = pcrg_pkg::B_CROSS_T;
			pcrg_pkg::B_CROSS_T: if (cnt_q == 3'd6) bstate_d = pcrg_pkg::B_LOAD;
			pcrg_pkg::B_LOAD: bstate_d = pcrg_pkg::B_NORM;
			pcrg_pkg::B_NORM: begin
				if (norm_zero)
					bstate_d = (vsel_q == 2'd2) ? pcrg_pkg::B_SC1 : pcrg_pkg::B_LOAD;
				else if (!norm_big && !norm_small)
					bstate_d = pcrg_pkg::B_SQ;
			end
			pcrg_pkg::B_SQ: if (cnt_q == 3'd3) bstate_d = pcrg_pkg::B_SQRT;
			pcrg_pkg::B_SQRT: if (bit_q[0]) bstate_d = pcrg_pkg::B_DIV;
			pcrg_pkg::B_DIV: begin
				if (dbit_q == 4'd0 && comp_q == 2'd2)
					bstate_d = (vsel_q == 2'd2) ? pcrg_pkg::B_SC1 : pcrg_pkg::B_LOAD;
			end
			pcrg_pkg::B_SC1: if (cnt_q == 3'd3) bstate_d = pcrg_pkg::B_SC2;
			pcrg_pkg::B_SC2: if (cnt_q == 3'd3) bstate_d = pcrg_pkg::B_IDLE;
			pcrg_pkg::B_IDLE: ;
		endcase
		// any register write rebuilds the basis
		if (cfg_wr) bstate_d = pcrg_pkg::B_CROSS_R;
		busy = (bstate_q != pcrg_pkg::B_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bstate_q <= pcrg_pkg::B_CROSS_R;
		else bstate_q <= bstate_d;
	end

	always_ff @(posedge clk) begin
		mul_q <= prod[49:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			vsel_q <= '0;
			comp_q <= '0;
			dbit_q <= '0;
			fault_q <= 1'b0;
		end else if (cfg_wr) begin
			cnt_q <= '0;
			vsel_q <= '0;
			fault_q <= 1'b0;
		end else begin
			unique case (bstate_q)
				pcrg_pkg::B_CROSS_R, pcrg_pkg::B_CROSS_T: begin
					cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
					if (cnt_q != 3'd0) begin
						if (!pc[0]) acc_q <= mul_q;
						else if (bstate_q == pcrg_pkg::B_CROSS_R)
							rv_q[pc[2:1]] <= 33'(acc_q - mul_q);
						else
							tv_q[pc[2:1]] <= 49'(acc_q - mul_q);
					end
				end
				pcrg_pkg::B_LOAD: begin
					for (int i = 0; i < 3; i++) begin
						mag_q[i] <= lmag[i];
						neg_q[i] <= lv[i][49];
					end
				end
				pcrg_pkg::B_NORM: begin
					if (norm_zero) begin
						// zero length: unit vector stays zero
						fault_q <= 1'b1;
						for (int i = 0; i < 3; i++) begin
							unique case (vsel_q)
								2'd0: du_q[i] <= '0;
								2'd1: ru_q[i] <= '0;
								default: tu_q[i] <= '0;
							endcase
						end
						if (vsel_q != 2'd2) vsel_q <= vsel_q + 2'd1;
						cnt_q <= '0;
					end else if (norm_big) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] >> 1;
					end else if (norm_small) begin
						for (int i = 0; i < 3; i++) mag_q[i] <= mag_q[i] << 1;
					end else begin
						cnt_q <= '0;
					end
				end
				pcrg_pkg::B_SQ: begin
					cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
					if (cnt_q == 3'd1) sum_q <= {1'b0, mul_q};
					else if (cnt_q == 3'd2) sum_q <= sum_q + {1'b0, mul_q};
					else if (cnt_q == 3'd3) begin
						n_q <= sum_q + {1'b0, mul_q};
						root_q <= '0;
						bit_q <= 51'd1 << 50;
					end
				end
				pcrg_pkg::B_SQRT: begin
					if (sq_ge) begin
						n_q <= 51'({1'b0, n_q} - sq_t);
						root_q <= (root_q >> 1) + {1'b0, bit_q};
					end else begin
						root_q <= root_q >> 1;
					end
					bit_q <= bit_q >> 2;
					if (bit_q[0]) begin
						comp_q <= '0;
						dbit_q <= 4'(pcrg_pkg::UNIT_BITS);
						quo_q <= '0;
						rem_q <= {2'b0, mag_q[0][23:0], 14'b0};
					end
				end
				pcrg_pkg::B_DIV: begin
					if (dbit_q == 4'd0) begin
						unique case (vsel_q)
							2'd0: du_q[comp_q] <= unit_val;
							2'd1: ru_q[comp_q] <= unit_val;
							default: tu_q[comp_q] <= unit_val;
						endcase
						if (comp_q == 2'd2) begin
							if (vsel_q != 2'd2) vsel_q <= vsel_q + 2'd1;
							cnt_q <= '0;
						end else begin
							comp_q <= comp_nx;
							rem_q <= {2'b0, mag_q[comp_nx][23:0], 14'b0};
							quo_q <= '0;
							dbit_q <= 4'(pcrg_pkg::UNIT_BITS);
						end
					end else begin
						quo_q <= qn;
						rem_q <= dv_ge ? rem_q - dv : rem_q;
						dbit_q <= dbit_q - 4'd1;
					end
				end
				pcrg_pkg::B_SC1: begin
					cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
					if (cnt_q != 3'd0) tmp_q[pc[1:0]] <= mul_q[31:0];
				end
				pcrg_pkg::B_SC2: begin
					cnt_q <= (cnt_q == 3'd3) ? 3'd0 : cnt_q + 3'd1;
					if (cnt_q != 3'd0) a_q[pc[1:0]] <= mul_q[44:0];
					vsel_q <= '0;
				end
				pcrg_pkg::B_IDLE: ;
			endcase
		end
	end

	// ---------------- pixel pipeline ----------------
	logic [NST-1:0] vld_q, en;
	logic take;

	// a stage moves when some stage at or after it is empty or the sink takes
	always_comb begin
		for (int k = 0; k < NST; k++)
			en[k] = ray.ready || ((vld_q | ((NST'(1) << k) - NST'(1))) != '1);
	end
	assign pix.ready = en[0] && !busy;
	assign take = pix.valid && pix.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else begin
			for (int k = 0; k < NST; k++)
				if (en[k]) vld_q[k] <= (k == 0) ? take : vld_q[(k == 0) ? 0 : k - 1];
		end
	end

	logic [pcrg_pkg::COORD_BITS-1:0] px_s1, py_s1;
	logic signed [13:0] nx_s2, ny_s2;
	logic signed [29:0] pr_s3 [3], pt_s3 [3];
	logic signed [45:0] acc_s4 [3];
	logic [NUM_W-1:0] num_s5 [3];
	logic neg_s5 [3], ovf_s5 [3];
	// divider stages, index j lives in stage s6+j
	logic [NUM_W-1:0] drem_s6 [QB][3];
	logic [QB-1:0] dquo_s6 [QB][3];
	logic dneg_s6 [QB][3], dovf_s6 [QB][3];
	logic signed [15:0] dir_s23 [3];
	logic sat_s23;

	logic [NUM_W-1:0] amag [3], anum [3];
	logic [NUM_W-1:0] drem_in [QB][3];
	logic [QB-1:0] dquo_in [QB][3];
	logic dneg_in [QB][3], dovf_in [QB][3];
	logic [QB-1:0] qf [3];
	logic signed [15:0] dir_nx [3];
	logic sat_l [3];
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			amag[i] = acc_s4[i][45] ? NUM_W'(-acc_s4[i]) : NUM_W'(acc_s4[i]);
			anum[i] = amag[i] + NUM_W'({h1, 13'b0});
			drem_in[0][i] = num_s5[i];
			dquo_in[0][i] = '0;
			dneg_in[0][i] = neg_s5[i];
			dovf_in[0][i] = ovf_s5[i];
			for (int j = 1; j < QB; j++) begin
				drem_in[j][i] = drem_s6[j-1][i];
				dquo_in[j][i] = dquo_s6[j-1][i];
				dneg_in[j][i] = dneg_s6[j-1][i];
				dovf_in[j][i] = dovf_s6[j-1][i];
			end
			// round half away from zero already folded in; clip to 16 bits
			qf[i] = dquo_s6[QB-1][i];
			sat_l[i] = 1'b0;
			if (dneg_s6[QB-1][i]) begin
				if (dovf_s6[QB-1][i] || qf[i] > 17'd32768) begin
					dir_nx[i] = -16'sd32768;
					sat_l[i] = 1'b1;
				end else begin
					dir_nx[i] = 16'(-$signed({1'b0, qf[i]}));
				end
			end else begin
				if (dovf_s6[QB-1][i] || qf[i] > 17'd32767) begin
					dir_nx[i] = 16'sd32767;
					sat_l[i] = 1'b1;
				end else begin
					dir_nx[i] = $signed(qf[i][15:0]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			px_s1 <= pix.pixel_x;
			py_s1 <= pix.pixel_y;
		end
		if (en[1]) begin
			nx_s2 <= $signed({1'b0, px_s1, 1'b0}) - $signed({2'b0, w1});
			ny_s2 <= $signed({1'b0, py_s1, 1'b0}) - $signed({2'b0, h1});
		end
		for (int i = 0; i < 3; i++) begin
			if (en[2]) begin
				pr_s3[i] <= ru_q[i] * nx_s2;
				pt_s3[i] <= tu_q[i] * ny_s2;
			end
			if (en[3])
				acc_s4[i] <= 46'(a_q[i])
					+ ((46'(pr_s3[i]) + 46'(pt_s3[i])) <<< pcrg_pkg::FRAC_BITS);
			if (en[4]) begin
				num_s5[i] <= anum[i];
				neg_s5[i] <= acc_s4[i][45];
				ovf_s5[i] <= anum[i] >= (NUM_W'(den) << QB);
			end
			for (int j = 0; j < QB; j++) begin
				if (en[DIVS + j]) begin
					if (drem_in[j][i] >= (NUM_W'(den) << (QB - 1 - j))) begin
						drem_s6[j][i] <= drem_in[j][i] - (NUM_W'(den) << (QB - 1 - j));
						dquo_s6[j][i] <= {dquo_in[j][i][QB-2:0], 1'b1};
					end else begin
						drem_s6[j][i] <= drem_in[j][i];
						dquo_s6[j][i] <= {dquo_in[j][i][QB-2:0], 1'b0};
					end
					dneg_s6[j][i] <= dneg_in[j][i];
					dovf_s6[j][i] <= dovf_in[j][i];
				end
			end
			if (en[NST-1]) dir_s23[i] <= dir_nx[i];
		end
		if (en[NST-1]) sat_s23 <= sat_l[0] || sat_l[1] || sat_l[2];
	end

	// outputs: origin comes straight from configuration, fault from the basis sequencer
	assign ray.valid = vld_q[NST-1];
	assign ray.origin_x = org_v[0];
	assign ray.origin_y = org_v[1];
	assign ray.origin_z = org_v[2];
	assign ray.dir_x = dir_s23[0];
	assign ray.dir_y = dir_s23[1];
	assign ray.dir_z = dir_s23[2];
	assign ray.saturated = sat_s23;
	assign ray.basis_fault = fault_q;

`include "pinhole_camera_ray_generator_assert.svh"
	`PCRG_ASSERT_IMPLY(a_busy_blocks, busy, !pix.ready, "pixel taken during basis pass")
	`PCRG_ASSERT_NEXT(a_cfg_rebuild, cfg_wr, busy, "register write did not restart basis")
	`PCRG_ASSERT_IMPLY(a_len_range, bstate_q == pcrg_pkg::B_DIV, (root_q[51:25] == '0) && (root_q[24:23] != 2'b00), "vector length out of normalized range")
	`PCRG_ASSERT_IMPLY(a_unit_bound, (bstate_q == pcrg_pkg::B_DIV) && (dbit_q == 4'd0), qn <= 15'd16384, "unit component above one")
endmodule
`default_nettype wire

// File: verif/pinhole_camera_ray_generator_test.sv
`default_nettype none
module pinhole_camera_ray_generator_test;
	import pcrg_pkg::*;

	// one expected ray, fields as the block presents them
	typedef struct {
		logic signed [COMP_W-1:0] ox, oy, oz, dx, dy, dz;
		logic fault, sat;
	} ray_t;

	// one row of the directed table: pixel and, where obvious, the expected ray
	typedef struct {
		logic [COORD_BITS-1:0] px, py;
		bit typed;
		ray_t want;
	} pix_row_t;

	localparam int WATCHDOG = 5000;

	logic clk = 0;
	logic arst_n = 0;
	logic psel = 0, penable = 0, pwrite = 0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	pcrg_pix_if pix ();
	pcrg_ray_if ray ();

	pinhole_camera_ray_generator i_dut (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix(pix.sink), .ray(ray.source)
	);

	always #5 clk = ~clk;

	// shadow copy of the camera registers
	logic [VEC_W-1:0] cam_origin, cam_view, cam_up;
	logic [15:0] cam_dist;
	logic [DIM_W-1:0] cam_width, cam_height;

	ray_t pending_rays[$];
	int errors = 0;
	int rays_seen = 0;
	int idle_cycles = 0;
	bit timed_out = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit pix_done = 0;

	initial begin
		pix.valid = 0;
		pix.pixel_x = '0;
		pix.pixel_y = '0;
		ray.ready = 0;
	end

	function automatic longint lane_of(logic [VEC_W-1:0] v, int k);
		logic signed [15:0] c;
		c = v[16*k +: 16];
		return longint'(c);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// unit vector in Q1.14, flags a zero vector
	task automatic normalize(input longint v[3], output longint u[3], inout bit fault);
		longint unsigned mag[3], m, sum, len;
		m = 0;
		sum = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = v[i] < 0 ? longint'(-v[i]) : longint'(v[i]);
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			u[0] = 0; u[1] = 0; u[2] = 0;
			fault = 1;
			return;
		end
		while (m >= (64'd1 << 24)) begin
			m >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (m < (64'd1 << 23)) begin
			m <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
		len = int_sqrt(sum);
		for (int i = 0; i < 3; i++) begin
			longint q;
			q = longint'((mag[i] << UNIT_BITS) / len);
			u[i] = v[i] < 0 ? -q : q;
		end
	endtask

	function automatic longint clamp_dim(logic [DIM_W-1:0] d);
		if (d < 2) return 2;
		if (d > 4096) return 4096;
		return longint'(d);
	endfunction

	task automatic trace_ray(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py,
			output ray_t r);
		longint d[3], up[3], rt[3], tp[3], du[3], ru[3], tu[3];
		longint w1, h1, nx, ny, acc, val;
		longint unsigned den, q;
		bit fault, sat;
		fault = 0;
		sat = 0;
		w1 = clamp_dim(cam_width) - 1;
		h1 = clamp_dim(cam_height) - 1;
		nx = 2 * longint'(px) - w1;
		ny = 2 * longint'(py) - h1;
		den = longint'(h1) << UNIT_BITS;
		for (int i = 0; i < 3; i++) begin
			d[i] = lane_of(cam_view, i);
			up[i] = lane_of(cam_up, i);
		end
		rt[0] = d[1] * up[2] - d[2] * up[1];
		rt[1] = d[2] * up[0] - d[0] * up[2];
		rt[2] = d[0] * up[1] - d[1] * up[0];
		tp[0] = d[1] * rt[2] - d[2] * rt[1];
		tp[1] = d[2] * rt[0] - d[0] * rt[2];
		tp[2] = d[0] * rt[1] - d[1] * rt[0];
		normalize(d, du, fault);
		normalize(rt, ru, fault);
		normalize(tp, tu, fault);
		for (int i = 0; i < 3; i++) begin
			acc = du[i] * longint'(cam_dist) * h1 + (ru[i] * nx + tu[i] * ny) * (64'sd1 << FRAC_BITS);
			q = ((acc < 0 ? longint'(-acc) : acc) + den / 2) / den;
			if (acc < 0) begin
				if (q > 32768) begin q = 32768; sat = 1; end
				val = -longint'(q);
			end else begin
				if (q > 32767) begin q = 32767; sat = 1; end
				val = longint'(q);
			end
			case (i)
				0: r.dx = val[15:0];
				1: r.dy = val[15:0];
				default: r.dz = val[15:0];
			endcase
		end
		r.ox = cam_origin[15:0];
		r.oy = cam_origin[31:16];
		r.oz = cam_origin[47:32];
		r.fault = fault;
		r.sat = sat;
	endtask

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch on ray %0d: %s got %0d expected %0d", rays_seen, what, got, want);
		errors++;
	endtask

	// ray side: random stall, compare against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && ray.valid && ray.ready) begin
			if (pending_rays.size() == 0) begin
				report_mismatch("unexpected ray", 0, 0);
			end else begin
				ray_t w;
				w = pending_rays.pop_front();
				if (ray.origin_x !== w.ox) report_mismatch("origin_x", ray.origin_x, w.ox);
				if (ray.origin_y !== w.oy) report_mismatch("origin_y", ray.origin_y, w.oy);
				if (ray.origin_z !== w.oz) report_mismatch("origin_z", ray.origin_z, w.oz);
				if (ray.dir_x !== w.dx) report_mismatch("dir_x", ray.dir_x, w.dx);
				if (ray.dir_y !== w.dy) report_mismatch("dir_y", ray.dir_y, w.dy);
				if (ray.dir_z !== w.dz) report_mismatch("dir_z", ray.dir_z, w.dz);
				if (ray.basis_fault !== w.fault)
					report_mismatch("basis_fault", ray.basis_fault, w.fault);
				if (ray.saturated !== w.sat) report_mismatch("saturated", ray.saturated, w.sat);
			end
			rays_seen++;
		end
	end

	always @(negedge clk) begin
		ray.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// watchdog: cycles with no request moving either way
	always @(posedge clk) begin
		if ((pix.valid && pix.ready) || (ray.valid && ray.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles >= WATCHDOG) begin
			$display("watchdog expired, %0d rays outstanding", pending_rays.size());
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
		@(negedge clk);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= ADDR_W'({idx, 3'b000});
		pwdata <= value;
		@(negedge clk);
		penable <= 1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		case (idx)
			REG_ORIGIN: cam_origin = value[VEC_W-1:0];
			REG_VIEW: cam_view = value[VEC_W-1:0];
			REG_UP: cam_up = value[VEC_W-1:0];
			REG_DIST: cam_dist = value[15:0];
			REG_WIDTH: cam_width = value[DIM_W-1:0];
			default: cam_height = value[DIM_W-1:0];
		endcase
	endtask

	// one pixel request: optional gap, hold valid until accepted
	task automatic send_pixel(input logic [COORD_BITS-1:0] px, input logic [COORD_BITS-1:0] py);
		ray_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			pix.valid <= 0;
			@(negedge clk);
		end
		pix.valid <= 1;
		pix.pixel_x <= px;
		pix.pixel_y <= py;
		trace_ray(px, py, r);
		do @(posedge clk); while (!pix.ready);
		pending_rays.push_back(r);
		@(negedge clk);
	endtask

	task automatic drain;
		pix.valid <= 0;
		while (pending_rays.size() != 0) @(negedge clk);
		// the block may still be rebuilding its basis; let the pipeline settle too
		repeat (40) @(negedge clk);
	endtask

	function automatic logic [VEC_W-1:0] pack_vec(int x, int y, int z);
		return {16'(z), 16'(y), 16'(x)};
	endfunction

	function automatic logic [VEC_W-1:0] rand_vec();
		case ($urandom_range(3))
			0: return {$urandom(), $urandom()} & 48'hFFFF_FFFF_FFFF;
			1: return pack_vec($urandom_range(1024) - 512, $urandom_range(1024) - 512,
				$urandom_range(1024) - 512);
			2: return pack_vec($urandom_range(1) ? 32767 : -32768, $urandom_range(511) - 256,
				$urandom_range(1) ? -32768 : 32767);
			default: return pack_vec($urandom_range(8) - 4, $urandom_range(8) - 4,
				$urandom_range(8) - 4);
		endcase
	endfunction

	// random camera, dimensions mostly legal but sometimes outside 2..4096
	task automatic random_camera;
		write_reg(REG_ORIGIN, {16'h0, rand_vec()});
		write_reg(REG_VIEW, {16'h0, rand_vec()});
		write_reg(REG_UP, {16'h0, rand_vec()});
		write_reg(REG_DIST, $urandom_range(1) ? $urandom_range(65535) : $urandom_range(1024));
		write_reg(REG_WIDTH, $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(4096, 2));
		write_reg(REG_HEIGHT, $urandom_range(9) == 0 ? $urandom_range(8191) : $urandom_range(4096, 2));
	endtask

	pix_row_t dir_rows[$];
	int phase_idle[4] = '{0, 47, 0, 33};
	int phase_stall[4] = '{0, 0, 47, 33};

	initial begin
		pix_row_t row;
		ray_t got_exp;
		cam_origin = '0;
		cam_view = 48'd256;
		cam_up = 48'd16777216;
		cam_dist = 16'd256;
		cam_width = 13'd640;
		cam_height = 13'd480;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed table; reset camera looks along +x with y up, right is +z
		// center row of a 640x480 image: sx = -1/479 -> dir (1.0, ~0, ~0)
		row = '{px: 12'd0, py: 12'd0, typed: 0, want: '{default: 0}};
		dir_rows.push_back(row);
		row.px = 12'd319; row.py = 12'd239; dir_rows.push_back(row);
		row.px = 12'd639; row.py = 12'd479; dir_rows.push_back(row);
		row.px = 12'd4095; row.py = 12'd4095; dir_rows.push_back(row);
		row.px = 12'd0; row.py = 12'd4095; dir_rows.push_back(row);
		row.px = 12'd4095; row.py = 12'd0; dir_rows.push_back(row);
		row.px = 12'hAAA; row.py = 12'h555; dir_rows.push_back(row);
		row.px = 12'h555; row.py = 12'hAAA; dir_rows.push_back(row);
		foreach (dir_rows[i]) send_pixel(dir_rows[i].px, dir_rows[i].py);
		drain();

		// zero view: every basis vector vanishes, direction is zero with the fault flag
		write_reg(REG_VIEW, '0);
		send_pixel(12'd100, 12'd200);
		got_exp = pending_rays[$];
		if (got_exp.dx != 0 || got_exp.dy != 0 || got_exp.dz != 0 || !got_exp.fault)
			report_mismatch("zero view prediction", 0, 0);
		pending_rays[$] = '{ox: 0, oy: 0, oz: 0, dx: 0, dy: 0, dz: 0, fault: 1, sat: 0};
		drain();

		// view parallel to up: cross product is zero, still faulted
		write_reg(REG_VIEW, pack_vec(0, 512, 0));
		write_reg(REG_ORIGIN, pack_vec(32767, -32768, 1));
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd320, 12'd240);
		drain();

		// extremes: far plane saturates, tiny and huge image sizes, clamped dimensions
		write_reg(REG_VIEW, pack_vec(-32768, 32767, -32768));
		write_reg(REG_UP, pack_vec(32767, 32767, 32767));
		write_reg(REG_DIST, 64'hFFFF);
		write_reg(REG_WIDTH, 64'd2);
		write_reg(REG_HEIGHT, 64'd2);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
		send_pixel(12'd4095, 12'd4095);
		drain();
		write_reg(REG_DIST, 64'd0);
		write_reg(REG_WIDTH, 64'd0);
		write_reg(REG_HEIGHT, 64'h1FFF);
		send_pixel(12'd0, 12'd4095);
		send_pixel(12'd4095, 12'd0);
		send_pixel(12'd1, 12'd2);
		drain();
		write_reg(REG_WIDTH, 64'd4096);
		write_reg(REG_HEIGHT, 64'd1);
		send_pixel(12'd4095, 12'd4095);
		send_pixel(12'd2048, 12'd0);
		drain();

		// random camera settings in four handshake phases
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = phase_idle[ph];
			recv_stall_pct = phase_stall[ph];
			for (int c = 0; c < 5; c++) begin
				random_camera();
				for (int n = 0; n < 55; n++) begin
					if ($urandom_range(4) == 0)
						send_pixel($urandom_range(4095), $urandom_range(4095));
					else
						send_pixel($urandom_range(clamp_dim(cam_width) - 1),
							$urandom_range(clamp_dim(cam_height) - 1));
				end
				drain();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		drain();

		$display("covered %0d rays over directed extremes and 20 random cameras", rays_seen);
		$display("four handshake phases, %0d mismatches", errors);
		if (errors == 0 && pending_rays.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire
